FILE: rtl/core/ole_pkg.sv
package ole_pkg;

    typedef enum logic [3:0] {
        OP_INS_FRONT = 4'd0,
        OP_INS_BACK  = 4'd1,
        OP_INS_AFTER = 4'd2,
        OP_INS_BEFORE = 4'd3,
        OP_INS_POS   = 4'd4,
        OP_DEL_FRONT = 4'd5,
        OP_DEL_BACK  = 4'd6,
        OP_DEL_KEY   = 4'd7,
        OP_DEL_POS   = 4'd8,
        OP_CLEAR     = 4'd9,
        OP_DEL_AFTER = 4'd10,
        OP_DEL_BEFORE = 4'd11,
        OP_DUMP      = 4'd12
    } op_t;

    localparam logic [2:0] ST_OK     = 3'd0;
    localparam logic [2:0] ST_EMPTY  = 3'd1;
    localparam logic [2:0] ST_NOKEY  = 3'd2;
    localparam logic [2:0] ST_BADPOS = 3'd3;
    localparam logic [2:0] ST_RANGE  = 3'd4;
    localparam logic [2:0] ST_FULL   = 3'd5;
    localparam logic [2:0] ST_SMALL  = 3'd6;

    localparam int OUT_W = 48; // status 3, element 32, length 7, pad 6

endpackage

FILE: rtl/core/ordered_list_engine_core.sv
// Ordered list engine: singly linked list in an on-chip node memory.
// Input channel s_axis_*: tdata = {position, value, key, op} from bit 0,
// one request per item. Result channel m_axis_*: tdata = {length, element,
// status}, tlast on the final result of a request.
// Every edit returns one result; a dump returns one result per element
// (one result with status empty when the list is empty).
// A request settled at decode (errors, clear, unused codes) goes straight
// to the result state. An insert at the front passes the fix and finish
// states; a delete at the front first reads the link of the head. A walk
// reads each node through a read and a check state; delete before key
// walks twice. A dump passes read, check and a wait state per element.
// One request is in flight at a time; s_axis_tready is high only while the
// engine waits for a request. A stalled receiver holds the result register;
// the engine keeps working and halts only when its next result is ready.
// Reset (aresetn low, synchronous) empties the list and the node allocator.
// Node memory contents are undefined until written; no clearing pass.
module ordered_list_engine_core
    import ole_pkg::*;
#(
    parameter int CAPACITY   = 64,
    parameter int VALUE_BITS = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [79:0] s_axis_tdata,  // op[3:0], key[35:4], value[67:36], position[74:68]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,  // status[2:0], element[34:3], length[41:35]
    output logic        m_axis_tlast
);
    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    typedef enum logic [7:0] {
        S_IDLE  = 8'b00000001,
        S_RD    = 8'b00000010,  // issue read of current node
        S_CHK   = 8'b00000100,  // data back: compare / step
        S_LINK  = 8'b00001000,  // read link of node to unlink, or of node before an insert
        S_FIX   = 8'b00010000,  // write relinks
        S_OUT   = 8'b00100000,
        S_DUMPW = 8'b01000000,
        S_FIN   = 8'b10000000
    } state_t;

    state_t state_reg;
    logic [3:0] op_reg;
    logic [VALUE_BITS-1:0] key_reg, val_reg;
    logic [IW-1:0] head_reg, cur_reg, prev_reg, tgt_reg;
    logic [CW-1:0] count_reg, idx_reg, goal_reg, rdepth_reg, fresh_reg;
    logic [2:0] st_reg;
    logic find_reg;   // walk searches for key (vs counts to goal)
    logic ins_reg;

    // node memories, single write port, registered read
    logic [VALUE_BITS-1:0] vmem [CAPACITY];
    logic [IW-1:0] lmem [CAPACITY];
    logic [IW-1:0] rstk [CAPACITY];
    logic [VALUE_BITS-1:0] vrd;
    logic [IW-1:0] lrd;
    logic [IW-1:0] rtop_reg;  // top of recycled stack, registered read
    logic [IW-1:0] raddr;
    logic vwe, lwe;
    logic [IW-1:0] vwa, lwa;
    logic [VALUE_BITS-1:0] vwd;
    logic [IW-1:0] lwd;

    always_ff @(posedge aclk) begin
        if (vwe) vmem[vwa] <= vwd;
        if (lwe) lmem[lwa] <= lwd;
        vrd <= vmem[raddr];
        lrd <= lmem[raddr];
        rtop_reg <= rstk[IW'(rdepth_reg - 1'b1)];
    end

    logic [VALUE_BITS-1:0] in_key, in_val;
    assign in_key = VALUE_BITS'(signed'(s_axis_tdata[35:4]));
    assign in_val = VALUE_BITS'(signed'(s_axis_tdata[67:36]));

    logic m_valid_reg, m_last_reg;
    logic [47:0] m_data_reg;
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tlast  = m_last_reg;
    assign s_axis_tready = (state_reg == S_IDLE);

    logic [31:0] elem_ext;
    assign elem_ext = 32'(signed'(vrd));

    // allocator pick; stack top settles while the request is decoded
    logic [IW-1:0] new_node;
    assign new_node = (rdepth_reg != '0) ? rtop_reg : IW'(fresh_reg);

    always_comb begin
        raddr = cur_reg;
        vwe = 1'b0; vwa = new_node; vwd = val_reg;
        lwe = 1'b0; lwa = new_node; lwd = head_reg;
        if (state_reg == S_FIX) begin
            if (ins_reg) begin
                vwe = 1'b1;
                lwe = 1'b1;
                lwd = (goal_reg == '0) ? head_reg : lrd;  // lrd = link of prev
            end else if (goal_reg != '0) begin
                lwe = 1'b1; lwa = prev_reg; lwd = lrd;   // lrd = link of target
            end
        end else if (state_reg == S_FIN && ins_reg && goal_reg != '0) begin
            lwe = 1'b1; lwa = prev_reg; lwd = new_node;
        end
        if (state_reg == S_LINK) raddr = tgt_reg;
        else if (state_reg == S_DUMPW) raddr = prev_reg;  // hold element while stalled
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            m_valid_reg <= 1'b0;
            head_reg <= '0; count_reg <= '0; rdepth_reg <= '0; fresh_reg <= '0;
        end else begin
            if (m_valid_reg && m_axis_tready) m_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE: if (s_axis_tvalid && s_axis_tready) begin
                    op_reg <= s_axis_tdata[3:0];
                    key_reg <= in_key; val_reg <= in_val;
                    cur_reg <= head_reg; prev_reg <= head_reg;
                    idx_reg <= '0; st_reg <= ST_OK;
                    find_reg <= 1'b0; ins_reg <= 1'b0;
                    state_reg <= S_OUT;
                    unique case (s_axis_tdata[3:0]) inside
                        OP_INS_FRONT: begin
                            ins_reg <= 1'b1; goal_reg <= '0;
                            if (count_reg >= CW'(CAPACITY)) st_reg <= ST_FULL;
                            else state_reg <= S_FIX;
                        end
                        OP_INS_BACK: begin
                            ins_reg <= 1'b1; goal_reg <= count_reg;
                            if (count_reg >= CW'(CAPACITY)) st_reg <= ST_FULL;
                            else if (count_reg == '0) state_reg <= S_FIX;
                            else state_reg <= S_RD;
                        end
                        OP_INS_POS: begin
                            ins_reg <= 1'b1;
                            goal_reg <= CW'(s_axis_tdata[74:68] - 7'd1);
                            if (s_axis_tdata[74:68] == 7'd0) st_reg <= ST_BADPOS;
                            else if (8'(s_axis_tdata[74:68]) > 8'(count_reg) + 8'd1)
                                st_reg <= ST_RANGE;
                            else if (count_reg >= CW'(CAPACITY)) st_reg <= ST_FULL;
                            else if (s_axis_tdata[74:68] == 7'd1) state_reg <= S_FIX;
                            else state_reg <= S_RD;
                        end
                        OP_INS_AFTER, OP_DEL_AFTER, OP_DEL_KEY, OP_INS_BEFORE: begin
                            find_reg <= 1'b1;
                            if (count_reg == '0)
                                st_reg <= (s_axis_tdata[3:0] == OP_INS_AFTER ||
                                           s_axis_tdata[3:0] == OP_DEL_AFTER)
                                          ? ST_NOKEY : ST_EMPTY;
                            else state_reg <= S_RD;
                        end
                        OP_DEL_BEFORE: begin
                            find_reg <= 1'b1;
                            if (count_reg < CW'(2)) st_reg <= ST_SMALL;
                            else state_reg <= S_RD;
                        end
                        OP_DEL_FRONT: begin
                            goal_reg <= '0;
                            if (count_reg == '0) st_reg <= ST_EMPTY;
                            else begin tgt_reg <= head_reg; state_reg <= S_LINK; end
                        end
                        OP_DEL_BACK: begin
                            goal_reg <= count_reg - 1'b1;
                            if (count_reg == '0) st_reg <= ST_EMPTY;
                            else if (count_reg == CW'(1)) begin
                                tgt_reg <= head_reg; state_reg <= S_LINK;
                            end else state_reg <= S_RD;
                        end
                        OP_DEL_POS: begin
                            goal_reg <= CW'(s_axis_tdata[74:68] - 7'd1);
                            if (count_reg == '0) st_reg <= ST_EMPTY;
                            else if (s_axis_tdata[74:68] == 7'd0) st_reg <= ST_BADPOS;
                            else if (8'(s_axis_tdata[74:68]) > 8'(count_reg))
                                st_reg <= ST_RANGE;
                            else if (s_axis_tdata[74:68] == 7'd1) begin
                                tgt_reg <= head_reg; state_reg <= S_LINK;
                            end else state_reg <= S_RD;
                        end
                        OP_CLEAR: begin
                            head_reg <= '0; count_reg <= '0;
                            rdepth_reg <= '0; fresh_reg <= '0;
                        end
                        OP_DUMP: begin
                            if (count_reg == '0) st_reg <= ST_EMPTY;
                            else state_reg <= S_RD;
                        end
                        default: ;
                    endcase
                end
                S_RD: state_reg <= S_CHK;
                S_CHK: begin
                    // vrd/lrd hold node cur_reg at place idx_reg
                    state_reg <= S_RD;
                    cur_reg <= lrd; prev_reg <= cur_reg;
                    idx_reg <= idx_reg + 1'b1;
                    if (op_reg == OP_DUMP) begin
                        state_reg <= S_DUMPW;
                    end else if (find_reg) begin
                        if (vrd == key_reg && !(op_reg == OP_DEL_BEFORE && idx_reg == '0)) begin
                            find_reg <= 1'b0;
                            unique case (op_reg)
                                OP_INS_AFTER: begin
                                    ins_reg <= 1'b1; goal_reg <= idx_reg + 1'b1;
                                    prev_reg <= cur_reg;
                                    if (count_reg >= CW'(CAPACITY)) begin
                                        st_reg <= ST_FULL; state_reg <= S_OUT;
                                    end else state_reg <= S_FIX;
                                end
                                OP_INS_BEFORE: begin
                                    ins_reg <= 1'b1; goal_reg <= idx_reg;
                                    if (count_reg >= CW'(CAPACITY)) begin
                                        st_reg <= ST_FULL; state_reg <= S_OUT;
                                    end else if (idx_reg == '0) state_reg <= S_FIX;
                                    else begin
                                        // read link of the node before the match
                                        prev_reg <= prev_reg; tgt_reg <= prev_reg;
                                        state_reg <= S_LINK;
                                    end
                                end
                                OP_DEL_KEY: begin
                                    goal_reg <= idx_reg; tgt_reg <= cur_reg;
                                    prev_reg <= prev_reg;
                                    state_reg <= S_LINK;
                                end
                                OP_DEL_AFTER: begin
                                    goal_reg <= idx_reg + 1'b1; tgt_reg <= lrd;
                                    prev_reg <= cur_reg;
                                    if (idx_reg + 1'b1 >= count_reg) begin
                                        st_reg <= ST_NOKEY; state_reg <= S_OUT;
                                    end else state_reg <= S_LINK;
                                end
                                default: begin // delete before key: restart walk
                                    goal_reg <= idx_reg - 1'b1;
                                    if (idx_reg == CW'(1)) begin
                                        tgt_reg <= head_reg; state_reg <= S_LINK;
                                    end else begin
                                        cur_reg <= head_reg; idx_reg <= '0;
                                        state_reg <= S_RD;
                                    end
                                end
                            endcase
                        end else if (idx_reg + 1'b1 >= count_reg) begin
                            st_reg <= ST_NOKEY; state_reg <= S_OUT;
                        end
                    end else if (idx_reg + 1'b1 == goal_reg) begin
                        // cur_reg is predecessor of place goal
                        prev_reg <= cur_reg;
                        if (ins_reg) state_reg <= S_FIX;
                        else begin tgt_reg <= lrd; state_reg <= S_LINK; end
                    end
                end
                S_LINK: state_reg <= S_FIX; // read tgt (delete) or prev (insert)
                S_FIX: begin
                    state_reg <= S_FIN;
                    if (!ins_reg && goal_reg == '0) head_reg <= lrd;
                end
                S_FIN: begin
                    if (ins_reg) begin
                        if (goal_reg == '0) head_reg <= new_node;
                        if (rdepth_reg != '0) rdepth_reg <= rdepth_reg - 1'b1;
                        else fresh_reg <= fresh_reg + 1'b1;
                        count_reg <= count_reg + 1'b1;
                    end else begin
                        rstk[IW'(rdepth_reg)] <= tgt_reg;
                        rdepth_reg <= rdepth_reg + 1'b1;
                        count_reg <= count_reg - 1'b1;
                        if (count_reg == CW'(1)) head_reg <= '0;
                    end
                    state_reg <= S_OUT;
                end
                S_OUT: if (!m_valid_reg) begin
                    m_valid_reg <= 1'b1; m_last_reg <= 1'b1;
                    m_data_reg <= {6'd0, 7'(count_reg), 32'd0, st_reg};
                    state_reg <= S_IDLE;
                end
                S_DUMPW: if (!m_valid_reg || m_axis_tready) begin
                    m_valid_reg <= 1'b1;
                    m_last_reg <= (idx_reg == count_reg);
                    m_data_reg <= {6'd0, 7'(count_reg), elem_ext, ST_OK};
                    state_reg <= (idx_reg == count_reg) ? S_IDLE : S_RD;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule

FILE: rtl/core/ole_checker.sv
module ole_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [47:0] m_axis_tdata,
    input logic        m_axis_tlast
);
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tlast |-> !(s_axis_tvalid && s_axis_tready))
        else $error("request taken in the middle of a dump");
    a_len: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> m_axis_tdata[41:35] <= 7'd64)
        else $error("length out of range");
    a_elem: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tlast |-> m_axis_tdata[2:0] == 3'd0)
        else $error("dump status not ok");
endmodule

bind ordered_list_engine_core ole_checker u_chk (.*);

FILE: verif/tb_top.sv
module tb_top;
    import ole_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CAP = 64;

    logic        aclk;
    logic        aresetn;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [79:0] s_axis_tdata;   // op[3:0], key[35:4], value[67:36], position[74:68]
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [47:0] m_axis_tdata;   // status[2:0], element[34:3], length[41:35]
    logic        m_axis_tlast;

    ordered_list_engine_core #(.CAPACITY(CAP), .VALUE_BITS(32)) dut (.*);

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    // One expected result: status, element, last and length.
    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] element;
        logic        last;
        logic [6:0]  length;
    } list_result_t;

    // Shadow list, kept as an ordered queue of element values.  Node indexes
    // are internal to the block and never visible at the ports, so order
    // alone decides every result.
    logic [31:0]  shadow_list[$];
    list_result_t pending_results[$];
    int           fail_count;
    int           send_idle_pct;
    int           recv_stall_pct;

    // Index of the first element at or after 'from' equal to k, or -1.
    function automatic int find_value(logic [31:0] k, int from);
        for (int i = from; i < shadow_list.size(); i++)
            if (shadow_list[i] == k) return i;
        return -1;
    endfunction

    function automatic void push_edit(logic [2:0] st);
        list_result_t r;
        r.status  = st;
        r.element = '0;
        r.last    = 1'b1;
        r.length  = 7'(shadow_list.size());
        pending_results.push_back(r);
    endfunction

    // Applies one request to the shadow list and queues what it returns.
    function automatic void predict_request(logic [3:0] op, logic [31:0] k,
                                            logic [31:0] v, logic [6:0] pos);
        int         cnt;
        int         f;
        logic [2:0] st;
        list_result_t r;
        cnt = shadow_list.size();
        st  = ST_OK;
        case (op)
            OP_DUMP: begin
                if (cnt == 0) begin
                    push_edit(ST_EMPTY);
                end else begin
                    for (int i = 0; i < cnt; i++) begin
                        r.status  = ST_OK;
                        r.element = shadow_list[i];
                        r.last    = (i == cnt - 1);
                        r.length  = 7'(cnt);
                        pending_results.push_back(r);
                    end
                end
                return;
            end
            OP_INS_FRONT: begin
                if (cnt >= CAP) st = ST_FULL;
                else shadow_list.push_front(v);
            end
            OP_INS_BACK: begin
                if (cnt >= CAP) st = ST_FULL;
                else shadow_list.push_back(v);
            end
            OP_INS_AFTER: begin
                f = find_value(k, 0);
                if (f < 0) st = ST_NOKEY;
                else if (cnt >= CAP) st = ST_FULL;
                else shadow_list.insert(f + 1, v);
            end
            OP_INS_BEFORE: begin
                if (cnt == 0) st = ST_EMPTY;
                else begin
                    f = find_value(k, 0);
                    if (f < 0) st = ST_NOKEY;
                    else if (cnt >= CAP) st = ST_FULL;
                    else shadow_list.insert(f, v);
                end
            end
            OP_INS_POS: begin
                if (pos == 0) st = ST_BADPOS;
                else if (pos > cnt + 1) st = ST_RANGE;
                else if (cnt >= CAP) st = ST_FULL;
                else shadow_list.insert(pos - 1, v);
            end
            OP_DEL_FRONT: begin
                if (cnt == 0) st = ST_EMPTY;
                else shadow_list.delete(0);
            end
            OP_DEL_BACK: begin
                if (cnt == 0) st = ST_EMPTY;
                else shadow_list.delete(cnt - 1);
            end
            OP_DEL_KEY: begin
                if (cnt == 0) st = ST_EMPTY;
                else begin
                    f = find_value(k, 0);
                    if (f < 0) st = ST_NOKEY;
                    else shadow_list.delete(f);
                end
            end
            OP_DEL_POS: begin
                if (cnt == 0) st = ST_EMPTY;
                else if (pos == 0) st = ST_BADPOS;
                else if (pos > cnt) st = ST_RANGE;
                else shadow_list.delete(pos - 1);
            end
            OP_CLEAR: shadow_list.delete();
            OP_DEL_AFTER: begin
                f = find_value(k, 0);
                if (f < 0 || f + 1 >= cnt) st = ST_NOKEY;
                else shadow_list.delete(f + 1);
            end
            OP_DEL_BEFORE: begin
                if (cnt < 2) st = ST_SMALL;
                else begin
                    f = find_value(k, 1);
                    if (f < 1) st = ST_NOKEY;
                    else shadow_list.delete(f - 1);
                end
            end
            default: ;  // unused codes: ok, no change
        endcase
        push_edit(st);
    endfunction

    // Sends one item; predicts at the accepting edge. Valid stays high
    // into the next item when no idle cycle follows.
    task automatic send_request(logic [3:0] op, logic [31:0] k, logic [31:0] v,
                                logic [6:0] pos);
        while (send_idle_pct > 0 && $urandom_range(99, 0) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {5'b0, pos, v, k, op};
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        predict_request(op, k, v, pos);
    endtask

    // Receiver stall and result check.
    always @(posedge aclk) begin
        list_result_t exp_r;
        if (aresetn) begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (pending_results.size() == 0) begin
                    $error("unexpected result %h", m_axis_tdata);
                    fail_count++;
                end else begin
                    exp_r = pending_results.pop_front();
                    if (m_axis_tdata[2:0] !== exp_r.status) begin
                        $error("status exp %0d got %0d", exp_r.status, m_axis_tdata[2:0]);
                        fail_count++;
                    end
                    if (m_axis_tdata[34:3] !== exp_r.element) begin
                        $error("element exp %h got %h", exp_r.element, m_axis_tdata[34:3]);
                        fail_count++;
                    end
                    if (m_axis_tlast !== exp_r.last) begin
                        $error("last exp %0b got %0b", exp_r.last, m_axis_tlast);
                        fail_count++;
                    end
                    if (m_axis_tdata[41:35] !== exp_r.length) begin
                        $error("length exp %0d got %0d", exp_r.length, m_axis_tdata[41:35]);
                        fail_count++;
                    end
                end
            end
        end
        m_axis_tready <= !(recv_stall_pct > 0 && $urandom_range(99, 0) < recv_stall_pct);
    end

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
    endtask

    // Key picked mostly from the list so searches hit.
    function automatic logic [31:0] pick_key();
        if (shadow_list.size() > 0 && $urandom_range(3, 0) != 0)
            return shadow_list[$urandom_range(shadow_list.size() - 1, 0)];
        return $urandom();
    endfunction

    // Extremes, every op, the error statuses but full, and the before-key fix.
    task automatic test_directed();
        send_request(OP_DUMP, 0, 0, 0);
        send_request(OP_DEL_FRONT, 0, 0, 0);
        send_request(OP_DEL_BACK, 0, 0, 0);
        send_request(OP_DEL_KEY, 0, 0, 0);
        send_request(OP_DEL_POS, 0, 0, 1);
        send_request(OP_INS_BEFORE, 0, 5, 0);
        send_request(OP_INS_AFTER, 0, 5, 0);
        send_request(OP_DEL_BEFORE, 0, 0, 0);
        send_request(OP_INS_POS, 0, 1, 0);
        send_request(OP_INS_POS, 0, 1, 7'd2);
        send_request(OP_INS_FRONT, 0, 32'h8000_0000, 0);
        send_request(OP_INS_BACK, 0, 32'h7fff_ffff, 0);
        send_request(OP_INS_POS, 0, 32'hffff_ffff, 7'd2);
        send_request(OP_INS_AFTER, 32'hffff_ffff, 32'd9, 0);
        send_request(OP_INS_BEFORE, 32'h8000_0000, 32'd3, 0);
        send_request(OP_DEL_POS, 0, 0, 0);
        send_request(OP_DEL_POS, 0, 0, 7'd127);
        // head match only: key not found
        send_request(OP_DEL_BEFORE, 32'd3, 0, 0);
        // removes the node just before the key
        send_request(OP_DEL_BEFORE, 32'd9, 0, 0);
        send_request(OP_DEL_AFTER, 32'h7fff_ffff, 0, 0);
        send_request(OP_DEL_AFTER, 32'd9, 0, 0);
        send_request(OP_DEL_KEY, 32'hffff_ffff, 0, 0);
        send_request(4'd13, 0, 0, 0);
        send_request(4'd15, 32'hffff_ffff, 32'hffff_ffff, 7'd127);
        send_request(OP_DUMP, 0, 0, 0);
        send_request(OP_CLEAR, 0, 0, 0);
    endtask

    // Fill to capacity, hit full, dump the whole store, clear, reuse.
    task automatic test_full_store();
        for (int i = 0; i < CAP; i++)
            send_request(OP_INS_BACK, 0, $urandom(), 0);
        send_request(OP_INS_FRONT, 0, 1, 0);
        send_request(OP_INS_POS, 0, 1, 7'd65);
        send_request(OP_INS_AFTER, shadow_list[3], 1, 0);
        send_request(OP_DUMP, 0, 0, 0);
        send_request(OP_DEL_POS, 0, 0, 7'd64);
        send_request(OP_DEL_POS, 0, 0, 7'd65);
        send_request(OP_CLEAR, 0, 0, 0);
        send_request(OP_INS_FRONT, 0, 32'h1234_5678, 0);
        send_request(OP_DUMP, 0, 0, 0);
    endtask

    task automatic test_random(int n);
        logic [3:0] op;
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(19, 0))
                0, 1, 2, 3:  op = OP_INS_BACK;
                4, 5:        op = OP_INS_FRONT;
                6:           op = OP_INS_POS;
                7:           op = OP_INS_AFTER;
                8:           op = OP_INS_BEFORE;
                9:           op = OP_DEL_FRONT;
                10:          op = OP_DEL_BACK;
                11:          op = OP_DEL_KEY;
                12:          op = OP_DEL_POS;
                13:          op = OP_DEL_AFTER;
                14:          op = OP_DEL_BEFORE;
                15, 16:      op = OP_DUMP;
                17:          op = ($urandom_range(9, 0) == 0) ? OP_CLEAR : OP_INS_BACK;
                18:          op = 4'($urandom_range(15, 13));
                default:     op = OP_INS_POS;
            endcase
            // keep lists short most of the time
            if (shadow_list.size() > 12 && op == OP_DUMP && $urandom_range(1, 0))
                op = OP_DEL_FRONT;
            send_request(op, pick_key(), $urandom(),
                         ($urandom_range(9, 0) == 0) ? 7'($urandom())
                             : 7'($urandom_range(shadow_list.size() + 1, 0)));
        end
    endtask

    initial begin
        aresetn        = 1'b0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        m_axis_tready  = 1'b1;
        fail_count     = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_full_store();
        test_random(90);
        send_idle_pct = 88;
        test_random(60);
        // hold off until everything is back
        wait_drained();
        send_idle_pct  = 0;
        recv_stall_pct = 88;
        test_random(60);
        send_idle_pct  = 17;
        recv_stall_pct = 17;
        test_random(60);

        wait_drained();
        repeat (200) @(posedge aclk);
        if (fail_count == 0 && pending_results.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("tb: failure");
        $finish;
    end

endmodule
